@@ src/vslru_pkg.sv @@
// ----------------------------------------------------------------------------
// Voice slot allocator package
// Shared types, transaction codes and sequencer states for the allocator.
// ----------------------------------------------------------------------------
package vslru_pkg;

   // Default size of the voice slot pool.
   localparam int NUM_SLOTS_DEFAULT = 16;

   // Request kinds carried in the kind field.
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_FINISH = 2'd1;
   localparam logic [1:0] KIND_STOP   = 2'd2;

   // Request transaction payload.
   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] slot;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic       granted;
      logic [3:0] slot_out;
      logic       evicted;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_EV_RD,
      ST_EV_DATA,
      ST_SHIFT_CHK,
      ST_SHIFT_WR,
      ST_SEARCH_CHK,
      ST_SEARCH_CMP,
      ST_PUSH,
      ST_PUSH_WR,
      ST_DONE
   } state_type;

   // Where the sequencer goes after a list entry has been removed.
   typedef enum logic [1:0] {
      CONT_EVICT,
      CONT_SEARCH,
      CONT_DROP
   } cont_type;

endpackage

@@ src/voice_slot_lru_allocator_top.sv @@
// ----------------------------------------------------------------------------
// Voice slot allocator with least-recently-started eviction
// Grants voice slots from a fixed pool, frees finished voices and clears the
// pool on stop-all. The start-order list lives in a small memory that one
// sequencer walks entry by entry.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_ready    vslru_pkg::req_type {kind, slot}
//   rsp_      out         rsp_valid/rsp_ready    vslru_pkg::rsp_type
//                                                {granted, slot_out, evicted}
//
// A start with a free slot scans the occupancy marks and then appends to the order list;
// an eviction adds a list shift and a search over the order memory, one entry at a time.
// A finished event searches the list and shifts out its entry; stop-all, ignored
// finishes and unused kinds go straight to the response. One transaction is in work at a
// time; req_ready is high only while idle. Reset is synchronous; a stalled rsp_ready
// holds back only the next transaction's completion.

module voice_slot_lru_allocator_top #(
   parameter int NUM_SLOTS = vslru_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  vslru_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output vslru_pkg::rsp_type rsp_data
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

   // Sequencer and data path registers.
   vslru_pkg::state_type state_ff, state_in;
   vslru_pkg::cont_type  cont_ff, cont_in;
   vslru_pkg::req_type   req_ff, req_in;
   vslru_pkg::rsp_type   rsp_ff;
   logic                 rsp_valid_ff;
   logic [NUM_SLOTS-1:0] occupied_ff, occupied_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [SLOT_W-1:0]    pick_ff, pick_in;
   logic                 evict_ff, evict_in;

   // Order memory and its port controls.
   logic [SLOT_W-1:0]    order_ff [NUM_SLOTS];
   logic [SLOT_W-1:0]    rdata_ff;
   logic                 mem_we;
   logic [SLOT_W-1:0]    mem_waddr;
   logic [SLOT_W-1:0]    mem_wdata;
   logic [SLOT_W-1:0]    mem_raddr;

   // Helpers.
   logic [SLOT_W+3:0]    slot_ext;
   logic [SLOT_W-1:0]    slot_idx;
   logic                 slot_ok;
   logic [CNT_W:0]       pos_inc;
   logic [SLOT_W+3:0]    pick_ext;
   logic                 is_start;
   logic                 rsp_load;

   assign slot_ext  = {{SLOT_W{1'b0}}, req_data.slot};
   assign slot_idx  = slot_ext[SLOT_W-1:0];
   assign slot_ok   = int'(req_data.slot) < NUM_SLOTS;
   assign pos_inc   = {1'b0, pos_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign pick_ext  = {4'b0000, pick_ff};
   assign is_start  = (req_ff.kind == vslru_pkg::KIND_START);

   assign req_ready = (state_ff == vslru_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= vslru_pkg::ST_IDLE;
         occupied_ff <= '0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         occupied_ff <= occupied_in;
         count_ff    <= count_in;
      end
   end

   // Working registers that need no reset.
   always_ff @(posedge clock) begin
      cont_ff  <= cont_in;
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      pick_ff  <= pick_in;
      evict_ff <= evict_in;
   end

   // Start-order memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         order_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= order_ff[mem_raddr];
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.granted  <= is_start;
         rsp_ff.slot_out <= is_start ? pick_ext[3:0] : req_ff.slot;
         rsp_ff.evicted  <= evict_ff;
      end
   end

   // Sequencer: next state, list walk and memory port control.
   always_comb begin
      state_in    = state_ff;
      cont_in     = cont_ff;
      req_in      = req_ff;
      occupied_in = occupied_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      pick_in     = pick_ff;
      evict_in    = evict_ff;
      mem_we      = 1'b0;
      mem_waddr   = pos_ff[SLOT_W-1:0];
      mem_wdata   = rdata_ff;
      mem_raddr   = '0;
      rsp_load    = 1'b0;

      unique case (state_ff)
         vslru_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               evict_in = 1'b0;
               idx_in   = '0;
               case (req_data.kind)
                  vslru_pkg::KIND_START: begin
                     state_in = vslru_pkg::ST_FIND;
                  end
                  vslru_pkg::KIND_FINISH: begin
                     if (slot_ok && occupied_ff[slot_idx]) begin
                        occupied_in[slot_idx] = 1'b0;
                        pick_in  = slot_idx;
                        cont_in  = vslru_pkg::CONT_SEARCH;
                        state_in = vslru_pkg::ST_SEARCH_CHK;
                     end else begin
                        state_in = vslru_pkg::ST_DONE;
                     end
                  end
                  vslru_pkg::KIND_STOP: begin
                     occupied_in = '0;
                     count_in    = '0;
                     state_in    = vslru_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = vslru_pkg::ST_DONE;
                  end
               endcase
            end
         end

         // Scan the occupancy marks for the lowest free slot.
         vslru_pkg::ST_FIND: begin
            if (!occupied_ff[idx_ff[SLOT_W-1:0]]) begin
               pick_in  = idx_ff[SLOT_W-1:0];
               state_in = vslru_pkg::ST_PUSH;
            end else if (idx_ff == CNT_W'(NUM_SLOTS - 1)) begin
               evict_in = 1'b1;
               if (count_ff == '0) begin
                  // Full pool with an empty list: fall back to slot zero.
                  pick_in  = '0;
                  idx_in   = '0;
                  cont_in  = vslru_pkg::CONT_SEARCH;
                  state_in = vslru_pkg::ST_SEARCH_CHK;
               end else begin
                  state_in = vslru_pkg::ST_EV_RD;
               end
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         // Fetch the oldest entry of the list.
         vslru_pkg::ST_EV_RD: begin
            mem_raddr = '0;
            state_in  = vslru_pkg::ST_EV_DATA;
         end

         vslru_pkg::ST_EV_DATA: begin
            pick_in  = rdata_ff;
            pos_in   = '0;
            cont_in  = vslru_pkg::CONT_EVICT;
            state_in = vslru_pkg::ST_SHIFT_CHK;
         end

         // Close the gap at pos by moving later entries down one place.
         vslru_pkg::ST_SHIFT_CHK: begin
            if (pos_inc < {1'b0, count_ff}) begin
               mem_raddr = pos_inc[SLOT_W-1:0];
               state_in  = vslru_pkg::ST_SHIFT_WR;
            end else begin
               count_in = count_ff - CNT_W'(1);
               case (cont_ff)
                  vslru_pkg::CONT_EVICT: begin
                     idx_in   = '0;
                     cont_in  = vslru_pkg::CONT_SEARCH;
                     state_in = vslru_pkg::ST_SEARCH_CHK;
                  end
                  vslru_pkg::CONT_DROP: begin
                     state_in = vslru_pkg::ST_PUSH_WR;
                  end
                  default: begin
                     state_in = is_start ? vslru_pkg::ST_PUSH : vslru_pkg::ST_DONE;
                  end
               endcase
            end
         end

         vslru_pkg::ST_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[SLOT_W-1:0];
            mem_wdata = rdata_ff;
            pos_in    = pos_inc[CNT_W-1:0];
            state_in  = vslru_pkg::ST_SHIFT_CHK;
         end

         // Search the list for the first entry that holds pick.
         vslru_pkg::ST_SEARCH_CHK: begin
            if (idx_ff < count_ff) begin
               mem_raddr = idx_ff[SLOT_W-1:0];
               state_in  = vslru_pkg::ST_SEARCH_CMP;
            end else begin
               state_in = is_start ? vslru_pkg::ST_PUSH : vslru_pkg::ST_DONE;
            end
         end

         vslru_pkg::ST_SEARCH_CMP: begin
            if (rdata_ff == pick_ff) begin
               pos_in   = idx_ff;
               cont_in  = vslru_pkg::CONT_SEARCH;
               state_in = vslru_pkg::ST_SHIFT_CHK;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = vslru_pkg::ST_SEARCH_CHK;
            end
         end

         // Append pick as newest; a full list drops its oldest entry first.
         vslru_pkg::ST_PUSH: begin
            if (int'(count_ff) >= NUM_SLOTS) begin
               pos_in   = '0;
               cont_in  = vslru_pkg::CONT_DROP;
               state_in = vslru_pkg::ST_SHIFT_CHK;
            end else begin
               state_in = vslru_pkg::ST_PUSH_WR;
            end
         end

         vslru_pkg::ST_PUSH_WR: begin
            mem_we               = 1'b1;
            mem_waddr            = count_ff[SLOT_W-1:0];
            mem_wdata            = pick_ff;
            count_in             = count_ff + CNT_W'(1);
            occupied_in[pick_ff] = 1'b1;
            state_in             = vslru_pkg::ST_DONE;
         end

         // Hand the result to the output register once it is free.
         vslru_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = vslru_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = vslru_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // The list never holds more entries than the pool has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= NUM_SLOTS)
      else $error("order list count exceeds pool size");

   // Between transactions the list holds as many entries as there are occupied slots.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vslru_pkg::ST_IDLE) |-> ($countones(occupied_ff) == int'(count_ff)))
      else $error("occupied slots and list count disagree");

   // An accepted transaction keeps the request side closed on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while sequencer busy");

   // An eviction is only ever reported on a grant.
   a_evict_granted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.evicted) |-> rsp_data.granted)
      else $error("eviction reported without a grant");
`endif

endmodule
